>>> rtl/second_order_recursive_lowpass_defines.svh
// Assertion macros for the second-order recursive low-pass filter.
// Used by the port checker; expects clk and rst_n in scope.
`ifndef SECOND_ORDER_RECURSIVE_LOWPASS_DEFINES_SVH
`define SECOND_ORDER_RECURSIVE_LOWPASS_DEFINES_SVH

// same-cycle implication, disabled during reset
`define SORL_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define SORL_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/sorl_pkg.sv
// Shared widths, register indexes and coefficient type for the
// second-order recursive low-pass filter. No dependencies.
package sorl_pkg;

    localparam int FRAC_BITS   = 16;
    localparam int DATA_W      = 32;
    localparam int COEF_W      = 19;
    localparam int PROD_W      = DATA_W + COEF_W;
    localparam int ACC_W       = PROD_W + 2;
    localparam int CFG_IDX_W   = 2;
    localparam int LIMIT_WHOLE = 1000;

    // register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_COEF_RECENT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_OLDER  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_INPUT  = 2'd2;

    localparam logic signed [COEF_W-1:0] COEF_INPUT_RESET = COEF_W'(65536);

    // accepted magnitude is strictly below LIMIT_WHOLE in fixed point
    localparam longint LIMIT_FIX = longint'(LIMIT_WHOLE) << FRAC_BITS;
    localparam logic signed [ACC_W-1:0] LIMIT_POS = ACC_W'(LIMIT_FIX);
    localparam logic signed [ACC_W-1:0] LIMIT_NEG = ACC_W'(-LIMIT_FIX);

    localparam logic signed [ACC_W-1:0] SAT_MAX = ACC_W'(64'sd2147483647);
    localparam logic signed [ACC_W-1:0] SAT_MIN = ACC_W'(-64'sd2147483648);

    typedef struct packed {
        logic signed [COEF_W-1:0] recent;
        logic signed [COEF_W-1:0] older;
        logic signed [COEF_W-1:0] inp;
    } coef_t;

endpackage

>>> rtl/sorl_cfg.sv
// Coefficient register file for the low-pass filter.
// Depends on sorl_pkg (register indexes, coef_t).
module sorl_cfg (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_write,
    input  logic [sorl_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [sorl_pkg::COEF_W-1:0]    cfg_data,
    output sorl_pkg::coef_t                coefs
);
    import sorl_pkg::*;

    coef_t coef_reg;
    coef_t coef_next;

    always_comb
    begin
        coef_next = coef_reg;
        if (cfg_write)
        begin
            unique case (cfg_index)
                REG_COEF_RECENT: coef_next.recent = cfg_data;
                REG_COEF_OLDER:  coef_next.older  = cfg_data;
                REG_COEF_INPUT:  coef_next.inp    = cfg_data;
                default:         coef_next        = coef_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_reg.recent <= '0;
            coef_reg.older  <= '0;
            coef_reg.inp    <= COEF_INPUT_RESET;
        end
        else
        begin
            coef_reg <= coef_next;
        end
    end

    assign coefs = coef_reg;

endmodule

>>> rtl/sorl_core.sv
// Filter datapath: input register, output history, multiply-accumulate,
// saturation and output register. Depends on sorl_pkg.
module sorl_core (
    input  logic                              clk,
    input  logic                              rst_n,
    input  sorl_pkg::coef_t                   coefs,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic signed [sorl_pkg::DATA_W-1:0] sample,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic signed [sorl_pkg::DATA_W-1:0] filtered,
    output logic                              accepted
);
    import sorl_pkg::*;

    logic                     s1_valid_reg;
    logic signed [DATA_W-1:0] s1_sample_reg;
    logic                     out_valid_reg;
    logic signed [DATA_W-1:0] filtered_reg;
    logic                     accepted_reg;
    logic signed [DATA_W-1:0] newest_reg;
    logic signed [DATA_W-1:0] newest_next;
    logic signed [DATA_W-1:0] older_reg;
    logic signed [DATA_W-1:0] older_next;
    logic                     primed_reg;
    logic                     primed_next;

    logic                     out_free;
    logic                     s1_fire;
    logic signed [ACC_W-1:0]  x_ext;
    logic                     in_range;
    logic signed [DATA_W-1:0] hist_new;
    logic signed [DATA_W-1:0] hist_old;
    logic signed [PROD_W-1:0] prod_recent;
    logic signed [PROD_W-1:0] prod_older;
    logic signed [PROD_W-1:0] prod_input;
    logic signed [ACC_W-1:0]  acc;
    logic signed [ACC_W-1:0]  shifted;
    logic signed [DATA_W-1:0] y;

    assign out_free = !out_valid_reg || !out_stall;
    assign s1_fire  = s1_valid_reg && out_free;
    assign in_stall = s1_valid_reg && !out_free;

    assign x_ext    = ACC_W'(s1_sample_reg);
    assign in_range = (x_ext < LIMIT_POS) && (x_ext > LIMIT_NEG);

    // first used sample stands in for both history slots
    assign hist_new = primed_reg ? newest_reg : s1_sample_reg;
    assign hist_old = primed_reg ? older_reg  : s1_sample_reg;

    assign prod_recent = PROD_W'(coefs.recent) * PROD_W'(hist_new);
    assign prod_older  = PROD_W'(coefs.older)  * PROD_W'(hist_old);
    assign prod_input  = PROD_W'(coefs.inp)    * PROD_W'(s1_sample_reg);

    assign acc     = ACC_W'(prod_recent) + ACC_W'(prod_older) + ACC_W'(prod_input);
    assign shifted = acc >>> FRAC_BITS;

    always_comb
    begin
        if (shifted > SAT_MAX)
            y = SAT_MAX[DATA_W-1:0];
        else if (shifted < SAT_MIN)
            y = SAT_MIN[DATA_W-1:0];
        else
            y = shifted[DATA_W-1:0];
    end

    always_comb
    begin
        newest_next = newest_reg;
        older_next  = older_reg;
        primed_next = primed_reg;
        if (s1_fire && in_range)
        begin
            newest_next = y;
            older_next  = hist_new;
            primed_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            newest_reg    <= '0;
            older_reg     <= '0;
            primed_reg    <= 1'b0;
        end
        else
        begin
            if (!in_stall)
                s1_valid_reg <= in_valid;
            if (out_free)
                out_valid_reg <= s1_valid_reg;
            newest_reg <= newest_next;
            older_reg  <= older_next;
            primed_reg <= primed_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
            s1_sample_reg <= sample;
        if (s1_fire)
        begin
            filtered_reg <= newest_next;
            accepted_reg <= in_range;
        end
    end

    assign out_valid = out_valid_reg;
    assign filtered  = filtered_reg;
    assign accepted  = accepted_reg;

endmodule

>>> rtl/second_order_recursive_lowpass.sv
// Top level of the second-order recursive low-pass filter.
// Depends on sorl_pkg, sorl_cfg and sorl_core.
//
//  channel  | handshake             | words
//  ---------+-----------------------+--------------------------
//  input    | in_valid / in_stall   | sample
//  output   | out_valid / out_stall | filtered, accepted
//  config   | cfg_write             | cfg_index, cfg_data
//
// One word per cycle unless a stall holds it. A word taken sits in the input
// register; the multiply-accumulate and saturation load the output register
// once it is free. The history feedback closes within that single stage.
// Reset clears the history, primed flag and recent and older coefficients,
// and sets the input coefficient to COEF_INPUT_RESET. An output stall holds
// the output word; in_stall rises only when the input register is also full.
module second_order_recursive_lowpass (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_write,
    input  logic [sorl_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [sorl_pkg::COEF_W-1:0]        cfg_data,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic signed [sorl_pkg::DATA_W-1:0] sample,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic signed [sorl_pkg::DATA_W-1:0] filtered,
    output logic                              accepted
);
    import sorl_pkg::*;

    coef_t coefs;

    sorl_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .coefs     (coefs)
    );

    sorl_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .coefs     (coefs),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .sample    (sample),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .filtered  (filtered),
        .accepted  (accepted)
    );

endmodule

>>> rtl/sorl_chk.sv
// Port-level checker for the low-pass filter, bound to the top level.
// Depends on sorl_pkg and second_order_recursive_lowpass_defines.svh.
`include "second_order_recursive_lowpass_defines.svh"

module sorl_chk (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              in_valid,
    input logic                              in_stall,
    input logic                              out_valid,
    input logic                              out_stall,
    input logic signed [sorl_pkg::DATA_W-1:0] filtered,
    input logic                              accepted
);
    import sorl_pkg::*;

    logic              in_take;
    logic              out_hold;
    logic [DATA_W:0]   out_word;

    assign in_take  = in_valid && !in_stall;
    assign out_hold = out_valid && out_stall;
    assign out_word = {filtered, accepted};

    // a new output word must trace back to a word taken at the input
    `SORL_ASSERT_NOW(a_out_follows_in, $rose(out_valid), $past(in_take, 2), "orphan output word")

    // input backs up only when the output side is full and stalled
    `SORL_ASSERT_NOW(a_stall_only_full, in_stall, out_hold, "needless input stall")

    `SORL_ASSERT_NEXT(a_out_hold, out_hold, out_valid && $stable(out_word), "held word changed")

    `SORL_ASSERT_NOW(a_out_drop, $fell(out_valid), $past(!out_stall), "dropped while stalled")

endmodule

bind second_order_recursive_lowpass sorl_chk u_sorl_chk (.*);

>>> bench/tb_second_order_recursive_lowpass.sv
// Self-checking bench for second_order_recursive_lowpass: random and directed samples,
// coefficient sweeps, and a scoreboard that predicts every filtered output word.
// Depends on sorl_pkg and the second_order_recursive_lowpass RTL.
module tb_second_order_recursive_lowpass;
    timeunit 1ns;
    timeprecision 1ps;

    import sorl_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
    localparam int CYCLE_LIMIT = 200000;
    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_WORDS = 135;
    localparam logic signed [COEF_W-1:0] COEF_MAX = 19'sh3ffff;
    localparam logic signed [COEF_W-1:0] COEF_MIN = -19'sh40000;
    localparam logic signed [DATA_W-1:0] BOUND = 32'sd65536000;

    typedef struct {
        logic signed [DATA_W-1:0] filtered;
        logic                     accepted;
    } filter_word_t;

    class lowpass_scoreboard;
        logic signed [COEF_W-1:0] c_recent;
        logic signed [COEF_W-1:0] c_older;
        logic signed [COEF_W-1:0] c_input;
        logic signed [DATA_W-1:0] y_newest;
        logic signed [DATA_W-1:0] y_older;
        bit                       primed;
        filter_word_t             pending_outputs[$];
        int                       errors;

        function new();
            c_recent = '0;
            c_older  = '0;
            c_input  = COEF_INPUT_RESET;
            y_newest = '0;
            y_older  = '0;
            primed   = 1'b0;
            errors   = 0;
        endfunction

        function void load_coef(logic [CFG_IDX_W-1:0] idx, logic signed [COEF_W-1:0] value);
            case (idx)
                REG_COEF_RECENT: c_recent = value;
                REG_COEF_OLDER:  c_older  = value;
                REG_COEF_INPUT:  c_input  = value;
                default: ;
            endcase
        endfunction

        // history update and the word the filter should emit for this sample
        function void take_sample(logic signed [DATA_W-1:0] x);
            longint       acc;
            bit           in_range;
            filter_word_t w;
            in_range = (longint'(x) < LIMIT_FIX) && (longint'(x) > -LIMIT_FIX);
            if (in_range) begin
                if (!primed) begin
                    y_newest = x;
                    y_older  = x;
                    primed   = 1'b1;
                end
                acc = longint'(c_recent) * longint'(y_newest)
                    + longint'(c_older) * longint'(y_older)
                    + longint'(c_input) * longint'(x);
                acc = acc >>> FRAC_BITS;
                y_older = y_newest;
                if (acc > 64'sd2147483647)
                    y_newest = 32'sh7fffffff;
                else if (acc < -64'sd2147483648)
                    y_newest = 32'sh80000000;
                else
                    y_newest = DATA_W'(acc);
            end
            w.filtered = y_newest;
            w.accepted = in_range;
            pending_outputs.push_back(w);
        endfunction

        function void check_output(logic signed [DATA_W-1:0] filtered, logic accepted);
            filter_word_t w;
            if (pending_outputs.size() == 0) begin
                $display("%0t: unexpected output word filtered=%0d accepted=%0b",
                         $time, filtered, accepted);
                errors++;
                return;
            end
            w = pending_outputs.pop_front();
            if (filtered !== w.filtered) begin
                $display("%0t: filtered mismatch expected=%0d actual=%0d",
                         $time, w.filtered, filtered);
                errors++;
            end
            if (accepted !== w.accepted) begin
                $display("%0t: accepted mismatch expected=%0b actual=%0b",
                         $time, w.accepted, accepted);
                errors++;
            end
        endfunction
    endclass

    logic                        clk;
    logic                        rst_n;
    logic                        cfg_write;
    logic [CFG_IDX_W-1:0]        cfg_index;
    logic [COEF_W-1:0]           cfg_data;
    logic                        in_valid;
    logic                        in_stall;
    logic signed [DATA_W-1:0]    sample;
    logic                        out_valid;
    logic                        out_stall;
    logic signed [DATA_W-1:0]    filtered;
    logic                        accepted;

    lowpass_scoreboard sb;
    bit                steady_run;
    int                cycle_count;

    second_order_recursive_lowpass dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .sample    (sample),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .filtered  (filtered),
        .accepted  (accepted)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // receiver: random stall, none during the steady stretch
    always @(posedge clk)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else
            out_stall <= !steady_run && ($urandom_range(0, 99) < 14);
    end

    always @(posedge clk)
    begin
        if (rst_n && in_valid && !in_stall)
            sb.take_sample(sample);
        if (rst_n && out_valid && !out_stall)
            sb.check_output(filtered, accepted);
    end

    // leaves in_valid high once the word is taken so the next word can follow directly
    task automatic send_sample(input logic signed [DATA_W-1:0] s);
        if (!steady_run && $urandom_range(0, 99) < 16) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        sample   <= s;
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending_outputs.size() != 0) @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    // all three coefficients, then a write to the unused index which must be ignored
    task automatic load_coefs(input logic signed [COEF_W-1:0] c_rec,
                              input logic signed [COEF_W-1:0] c_old,
                              input logic signed [COEF_W-1:0] c_inp);
        logic [COEF_W-1:0] junk;
        junk      = COEF_W'($urandom);
        cfg_write <= 1'b1;
        cfg_index <= REG_COEF_RECENT;
        cfg_data  <= c_rec;
        @(posedge clk);
        sb.load_coef(REG_COEF_RECENT, c_rec);
        cfg_index <= REG_COEF_OLDER;
        cfg_data  <= c_old;
        @(posedge clk);
        sb.load_coef(REG_COEF_OLDER, c_old);
        cfg_index <= REG_COEF_INPUT;
        cfg_data  <= c_inp;
        @(posedge clk);
        sb.load_coef(REG_COEF_INPUT, c_inp);
        cfg_index <= REG_UNUSED;
        cfg_data  <= junk;
        @(posedge clk);
        sb.load_coef(REG_UNUSED, junk);
        cfg_write <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic signed [COEF_W-1:0] rand_coef(int kind);
        case (kind)
            0: return COEF_W'($urandom);
            1: begin
                case ($urandom_range(0, 3))
                    0: return COEF_MAX;
                    1: return COEF_MIN;
                    2: return '0;
                    default: return COEF_INPUT_RESET;
                endcase
            end
            default: return COEF_W'($urandom_range(0, 40000)) - COEF_W'(20000);
        endcase
    endfunction

    initial
    begin
        int                       kind;
        int                       pick;
        logic signed [DATA_W-1:0] s;
        sb          = new();
        steady_run  = 1'b0;
        rst_n     <= 1'b0;
        cfg_write <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        in_valid  <= 1'b0;
        sample    <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset coefficients: rejected words before priming must read back zero
        send_sample(BOUND);
        send_sample(-BOUND);
        send_sample(32'sh7fffffff);
        send_sample(32'sh80000000);
        send_sample(BOUND - 1);     // first accepted word fills both history slots
        send_sample(-(BOUND - 1));
        send_sample(BOUND + 1);
        send_sample(32'sd0);
        send_sample(-32'sd1);
        send_sample(32'sd1);
        send_sample(32'sh0000ffff);
        send_sample(-BOUND - 1);
        drain();

        // largest gains drive the output into positive saturation
        load_coefs(COEF_MAX, COEF_MAX, COEF_MAX);
        send_sample(BOUND - 1);
        send_sample(BOUND - 1);
        send_sample(BOUND - 1);
        send_sample(BOUND - 1);
        send_sample(32'sh7fffffff);
        drain();

        // most negative gains on a saturated history clamp to the bottom
        load_coefs(COEF_MIN, COEF_MIN, COEF_MIN);
        send_sample(BOUND - 1);
        send_sample(BOUND - 1);
        send_sample(-(BOUND - 1));
        send_sample(32'sh80000000);
        send_sample(32'sd12345);
        drain();

        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            kind = phase % 3;
            if (kind == 2)
                load_coefs(COEF_W'($urandom_range(70000, 110000)),
                           -COEF_W'($urandom_range(20000, 50000)),
                           COEF_W'($urandom_range(1000, 20000)));
            else
                load_coefs(rand_coef(kind), rand_coef(kind), rand_coef(kind));
            steady_run = (phase == 4);
            for (int n = 0; n < PHASE_WORDS; n++) begin
                pick = $urandom_range(0, 99);
                if (pick < 65)
                    s = DATA_W'($urandom_range(0, 131071998)) - 32'sd65535999;
                else if (pick < 80)
                    s = DATA_W'($urandom);
                else if (pick < 90)
                    s = ($urandom_range(0, 1) ? BOUND : -BOUND)
                        + DATA_W'(int'($urandom_range(0, 4)) - 2);
                else
                    s = DATA_W'(int'($urandom_range(0, 511)) - 256);
                send_sample(s);
            end
            steady_run = 1'b0;
            drain();
        end

        repeat (10) @(posedge clk);
        if (sb.errors == 0 && sb.pending_outputs.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
